// ===== rtl/mspt_pkg.sv =====
// Shared types and constants for the periodic task timer.
`default_nettype none

package mspt_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int MASK_W        = 16;
   localparam int FUNC_W        = 3;
   localparam int SLOT_W        = 4;
   localparam int WORD_W        = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK        = 3'd0,
      FUNC_ADD         = 3'd1,
      FUNC_CLEAR       = 3'd2,
      FUNC_RESTART     = 3'd3,
      FUNC_CLEAR_ALL   = 3'd4,
      FUNC_SET_COUNTER = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_RESTART,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [SLOT_W-1:0] slot;
      logic [WORD_W-1:0] period;
      logic [WORD_W-1:0] counter_value;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [MASK_W-1:0] fired_mask;
      logic [WORD_W-1:0] tick_count;
      logic [WORD_W-1:0] user_counter;
   } rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0] period;
      logic [WORD_W-1:0] count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

// ===== rtl/multi_slot_periodic_task_timer_core.sv =====
// Top level of the multi-slot periodic task timer.
//
//   channel   direction   payload     handshake
//   req       in          req_type    req_valid / req_stall
//   rsp       out         rsp_type    rsp_valid / rsp_stall
//
// One item at a time. A tick walks every slot in ST_WALK, then goes to ST_DONE:
// the walk reads and writes back one slot entry per cycle through the slot RAM.
// Restart of an in-range slot passes ST_RESTART; ST_DONE loads the output register.
// Reset clears the slot valid flags at once; RAM contents need no clearing pass.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and its result waits until the register frees.
`default_nettype none

module multi_slot_periodic_task_timer_core
   import mspt_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(SLOTS);

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              ok_ff, ok_in;
   logic [WORD_W-1:0] tick_ff, tick_in;
   logic [WORD_W-1:0] user_ff, user_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   entry_type         ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   entry_type         ram_rd_data;

   logic [AW-1:0]     req_addr;
   logic              req_slot_ok;
   logic [AW-1:0]     cur_addr;
   entry_type         entry_eff;
   logic [WORD_W-1:0] cnt_next;
   logic              active;
   logic              hit;
   logic [MASK_W-1:0] fire_sel;

   mspt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_addr    = AW'(req_data.slot);
   assign req_slot_ok = (req_data.slot != '0) && (32'(req_data.slot) < 32'(SLOTS));
   assign cur_addr    = (state_ff == ST_WALK) ? idx_ff : AW'(req_ff.slot);
   assign entry_eff   = valid_ff[cur_addr] ? ram_rd_data : '0;
   assign cnt_next    = entry_eff.count + 32'd1;
   assign active      = entry_eff.period != '0;
   assign hit         = cnt_next == entry_eff.period;

   always_comb begin
      for (int j = 0; j < MASK_W; j++) begin
         fire_sel[j] = 32'(idx_ff) == 32'(j);
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      mask_in      = mask_ff;
      ok_in        = ok_ff;
      tick_in      = tick_ff;
      user_in      = user_ff;
      valid_in     = valid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cur_addr;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = req_addr;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               mask_in  = '0;
               ok_in    = 1'b0;
               state_in = ST_DONE;
               case (req_data.func)
                  FUNC_TICK: begin
                     tick_in     = tick_ff + 32'd1;
                     user_in     = user_ff + 32'd1;
                     ok_in       = 1'b1;
                     idx_in      = '0;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     state_in    = ST_WALK;
                  end
                  FUNC_ADD: begin
                     if (req_slot_ok) begin
                        ram_wr_en          = 1'b1;
                        ram_wr_addr        = req_addr;
                        ram_wr_data.period = req_data.period;
                        ram_wr_data.count  = '0;
                        valid_in[req_addr] = 1'b1;
                        ok_in              = req_data.period != '0;
                     end
                  end
                  FUNC_CLEAR: begin
                     if (req_slot_ok) begin
                        valid_in[req_addr] = 1'b0;
                        ok_in              = 1'b1;
                     end
                  end
                  FUNC_RESTART: begin
                     if (req_slot_ok) begin
                        ram_rd_en = 1'b1;
                        state_in  = ST_RESTART;
                     end
                  end
                  FUNC_CLEAR_ALL: begin
                     valid_in = '0;
                     ok_in    = 1'b1;
                  end
                  FUNC_SET_COUNTER: begin
                     user_in = req_data.counter_value;
                     ok_in   = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (active) begin
               ram_wr_en          = 1'b1;
               ram_wr_data.period = entry_eff.period;
               ram_wr_data.count  = hit ? '0 : cnt_next;
               if (hit) begin
                  mask_in = mask_ff | fire_sel;
               end
            end
            if (idx_ff == AW'(SLOTS - 1)) begin
               state_in = ST_DONE;
            end else begin
               idx_in      = idx_ff + AW'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + AW'(1);
            end
         end
         ST_RESTART: begin
            if (active) begin
               ram_wr_en          = 1'b1;
               ram_wr_data.period = entry_eff.period;
               ram_wr_data.count  = '0;
               ok_in              = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.ok           = ok_ff;
               rsp_in.fired_mask   = mask_ff;
               rsp_in.tick_count   = tick_ff;
               rsp_in.user_counter = user_ff;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         user_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         user_ff      <= user_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      idx_ff  <= idx_in;
      mask_ff <= mask_in;
      ok_ff   <= ok_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/mspt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mspt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/mspt_checker.sv =====
// Port-level checks for the periodic task timer, bound to the top level.
`default_nettype none

module mspt_checker
   import mspt_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transfer taken while an item is in work");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.fired_mask != '0) |-> rsp_data.ok)
      else $error("fired slots reported on a refused item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.fired_mask[0])
      else $error("slot zero fired");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind multi_slot_periodic_task_timer_core mspt_checker u_mspt_checker (.*);

`default_nettype wire
